FILE: rtl/wphc_pkg.sv
// Shared types and constants for the WoLF-PHC learning update unit.
// No dependencies; used by wphc_div and wolf_phc_learning_update_unit.
package wphc_pkg;

  // fixed field widths of one beat
  localparam int AGENT_W = 3;
  localparam int POS_W   = 5;
  localparam int ACT_W   = 3;
  localparam int ADDR_W  = AGENT_W + POS_W + ACT_W;
  localparam int VADDR_W = AGENT_W + POS_W;
  localparam int MEM_DEPTH  = 1 << ADDR_W;
  localparam int VMEM_DEPTH = 1 << VADDR_W;
  localparam int ACT_MAX = 1 << ACT_W;

  // Q reset value: 10.0 in Q16.16
  localparam logic signed [31:0] Q_RESET = 32'sd655360;
  localparam logic [16:0] PROB_ONE = 17'h10000;

  // shared divider widths
  localparam int DIV_NW = 34;
  localparam int DIV_DW = 20;

  // register indexes
  localparam logic [1:0] REG_LEARN_RATE = 2'd0;
  localparam logic [1:0] REG_DISCOUNT   = 2'd1;
  localparam logic [1:0] REG_WIN_STEP   = 2'd2;
  localparam logic [1:0] REG_LOSE_STEP  = 2'd3;

  typedef struct packed {
    logic [2:0]         agent;
    logic [4:0]         position;
    logic [2:0]         action;
    logic [4:0]         next_position;
    logic signed [31:0] reward;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] updated_q;
    logic [2:0]         greedy_action;
    logic               winning;
    logic               renormalized;
  } out_beat_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_NW-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [20:0] {
    ST_CLEAR  = 21'h000001,
    ST_IDLE   = 21'h000002,
    ST_MAXN   = 21'h000004,
    ST_QOLD   = 21'h000008,
    ST_MULG   = 21'h000010,
    ST_MULA   = 21'h000020,
    ST_QWR    = 21'h000040,
    ST_ARD    = 21'h000080,
    ST_AWAIT  = 21'h000100,
    ST_ADIV   = 21'h000200,
    ST_AWR    = 21'h000400,
    ST_AMUL   = 21'h000800,
    ST_AACC   = 21'h001000,
    ST_SSTART = 21'h002000,
    ST_SDIV   = 21'h004000,
    ST_HRD    = 21'h008000,
    ST_HWR    = 21'h010000,
    ST_NSTART = 21'h020000,
    ST_NDIV   = 21'h040000,
    ST_NWR    = 21'h080000,
    ST_DONE   = 21'h100000
  } state_t;

  // clamp a signed probability to 0..1.0
  function automatic logic [16:0] clamp_prob(input logic signed [18:0] v);
    logic [16:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > 19'sd65536) begin
      r = PROB_ONE;
    end else begin
      r = v[16:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/wphc_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on wphc_pkg for the request and response structs.
module wphc_div (
  input  logic                clk,
  input  logic                rst_n,
  input  wphc_pkg::div_req_t  req,
  output wphc_pkg::div_rsp_t  rsp
);

  logic                         busy_r;
  logic                         done_r;
  logic [5:0]                   cnt_r;
  logic [wphc_pkg::DIV_DW-1:0]  rem_r;
  logic [wphc_pkg::DIV_NW-1:0]  quo_r;
  logic [wphc_pkg::DIV_DW-1:0]  dvs_r;
  logic [wphc_pkg::DIV_DW:0]    shift_w;
  logic [wphc_pkg::DIV_DW:0]    diff_w;
  logic                         fit_w;

  // trial subtract of the shifted remainder
  assign shift_w = {rem_r, quo_r[wphc_pkg::DIV_NW-1]};
  assign diff_w  = shift_w - {1'b0, dvs_r};
  assign fit_w   = shift_w >= {1'b0, dvs_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(wphc_pkg::DIV_NW - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // datapath: quotient bits shift in as dividend bits shift out
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= fit_w ? diff_w[wphc_pkg::DIV_DW-1:0] : shift_w[wphc_pkg::DIV_DW-1:0];
      quo_r <= {quo_r[wphc_pkg::DIV_NW-2:0], fit_w};
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

FILE: rtl/wolf_phc_learning_update_unit.sv
// WoLF-PHC learning update: Q update, average policy, policy hill climb.
// Depends on wphc_pkg and instantiates the shared divider wphc_div.
//
//  channel | ports                     | beat
//  --------+---------------------------+----------------------------------
//  input   | in_valid/in_ready/in_data | agent, states, action, reward
//  output  | out_valid/out_ready/...   | new Q, greedy action, flags
//  config  | cfg_psel...cfg_pready     | alpha, gamma, win and lose steps
//
// After reset a clearing pass writes every entry of all stores; no beat is
// taken meanwhile. Each item then finds the max next-state Q, updates Q,
// updates the average policy of each action and climbs the policy, and it
// renormalizes when an entry goes negative; each division waits on the one shared divider.
// Out-of-range items skip the update and give a zero beat. The output register frees the core while
// a result waits; a stalled output holds the next result in the final state.
module wolf_phc_learning_update_unit #(
  parameter int AGENT_COUNT  = 5,
  parameter int STATE_COUNT  = 32,
  parameter int ACTION_COUNT = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  wphc_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output wphc_pkg::out_beat_t  out_data,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [3:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);

  localparam logic [16:0] PROB_RESET = 17'(65536 / ACTION_COUNT);
  localparam logic [3:0]  K_LAST     = 4'(ACTION_COUNT - 1);
  localparam logic [3:0]  K_END      = 4'(ACTION_COUNT);
  // reciprocal of N-1, exact floor for 16-bit steps
  localparam int          SHARE_SHIFT = 20;
  localparam logic [20:0] SHARE_RECIP =
    21'(((1 << SHARE_SHIFT) + ACTION_COUNT - 2) / (ACTION_COUNT - 1));

  wphc_pkg::state_t state_r, state_nxt;

  // configuration registers
  logic [15:0] learn_rate_r, discount_r, win_step_r, lose_step_r;

  // item and working registers
  wphc_pkg::in_beat_t    item_r;
  logic                  bad_r;
  logic [3:0]            k_r;
  logic [10:0]           clr_r;
  logic signed [31:0]    maxq_r, qold_r, qk_r, gq_r, resq_r;
  logic [15:0]           cnt_r;
  logic [16:0]           p_r, avg_r, avgn_r;
  logic                  dneg_r;
  logic signed [52:0]    prod_r;
  logic signed [55:0]    diff_r;
  logic [2:0]            greedy_r;
  logic                  win_r, renorm_r;
  logic [15:0]           share_r;
  logic signed [18:0]    m_r;
  logic signed [18:0]    ptmp_r [wphc_pkg::ACT_MAX];
  wphc_pkg::out_beat_t   out_r;
  logic                  out_valid_r;

  // memories
  logic signed [31:0] q_mem   [wphc_pkg::MEM_DEPTH];
  logic [16:0]        p_mem   [wphc_pkg::MEM_DEPTH];
  logic [16:0]        avg_mem [wphc_pkg::MEM_DEPTH];
  logic [15:0]        v_mem   [wphc_pkg::VMEM_DEPTH];
  logic signed [31:0] q_rd_r;
  logic [16:0]        p_rd_r, avg_rd_r;
  logic [15:0]        v_rd_r;

  logic [wphc_pkg::ADDR_W-1:0]  q_raddr, q_waddr, pa_addr, p_waddr, a_waddr;
  logic [wphc_pkg::VADDR_W-1:0] v_addr, v_waddr;
  logic               q_we, p_we, a_we, v_we;
  logic signed [31:0] q_wdata;
  logic [16:0]        p_wdata, a_wdata;
  logic [15:0]        v_wdata;

  // shared multiplier
  logic signed [34:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [52:0] mul_p;

  // datapath terms
  logic signed [34:0] target_w;
  logic signed [36:0] nq_w;
  logic signed [31:0] nq_sat_w;
  logic signed [17:0] dpa_w, dpa_mag_w, avg_new_w, quo_s_w;
  logic [18:0]        gain_w;
  logic signed [18:0] pn_w, m_nxt_w, numr_w;
  logic [17:0]        negm_w;
  logic [19:0]        den_w;
  logic [16:0]        quo_clamp_w;
  logic               in_range_w, slot_free_w;
  logic [15:0]        cnt_inc_w;
  logic [36:0]        share_prod_w;

  wphc_pkg::div_req_t div_req;
  wphc_pkg::div_rsp_t div_rsp;

  wphc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // handshakes
  assign in_ready    = (state_r == wphc_pkg::ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_data    = out_r;
  assign slot_free_w = !out_valid_r || out_ready;
  assign cfg_pready  = 1'b1;

  assign in_range_w = (32'(in_data.agent) < AGENT_COUNT) &&
                      (32'(in_data.position) < STATE_COUNT) &&
                      (32'(in_data.next_position) < STATE_COUNT) &&
                      (32'(in_data.action) < ACTION_COUNT);

  // register reads
  always_comb begin
    case (cfg_paddr[3:2])
      wphc_pkg::REG_LEARN_RATE: cfg_prdata = {16'h0, learn_rate_r};
      wphc_pkg::REG_DISCOUNT:   cfg_prdata = {16'h0, discount_r};
      wphc_pkg::REG_WIN_STEP:   cfg_prdata = {16'h0, win_step_r};
      wphc_pkg::REG_LOSE_STEP:  cfg_prdata = {16'h0, lose_step_r};
      default:                  cfg_prdata = '0;
    endcase
  end

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learn_rate_r <= 16'd6554;
      discount_r   <= 16'd58982;
      win_step_r   <= 16'd655;
      lose_step_r  <= 16'd2621;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      case (cfg_paddr[3:2])
        wphc_pkg::REG_LEARN_RATE: learn_rate_r <= cfg_pwdata[15:0];
        wphc_pkg::REG_DISCOUNT:   discount_r   <= cfg_pwdata[15:0];
        wphc_pkg::REG_WIN_STEP:   win_step_r   <= cfg_pwdata[15:0];
        wphc_pkg::REG_LOSE_STEP:  lose_step_r  <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // multiplier operand select
  always_comb begin
    case (state_r)
      wphc_pkg::ST_MULG: begin
        mul_a = 35'(maxq_r);
        mul_b = $signed({2'b00, discount_r});
      end
      wphc_pkg::ST_MULA: begin
        mul_a = target_w;
        mul_b = $signed({2'b00, learn_rate_r});
      end
      default: begin
        mul_a = 35'(qk_r);
        mul_b = $signed({1'b0, p_r}) - $signed({1'b0, avgn_r});
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Q update terms
  assign target_w = 35'(item_r.reward) + 35'(prod_r >>> 16) - 35'(qold_r);
  assign nq_w     = 37'(qold_r) + 37'(prod_r >>> 16);
  always_comb begin
    if (nq_w > 37'sd2147483647) begin
      nq_sat_w = 32'sh7fffffff;
    end else if (nq_w < -37'sd2147483648) begin
      nq_sat_w = 32'sh80000000;
    end else begin
      nq_sat_w = nq_w[31:0];
    end
  end
  assign cnt_inc_w = (v_rd_r == 16'hffff) ? v_rd_r : v_rd_r + 16'd1;

  // average policy terms
  assign dpa_w     = $signed({1'b0, p_rd_r}) - $signed({1'b0, avg_rd_r});
  assign dpa_mag_w = dpa_w[17] ? -dpa_w : dpa_w;
  assign quo_s_w   = $signed({1'b0, div_rsp.quotient[16:0]});
  assign avg_new_w = $signed({1'b0, avg_r}) + (dneg_r ? -quo_s_w : quo_s_w);

  // step share: step / (N-1) by reciprocal multiply
  assign share_prod_w = 37'(win_r ? win_step_r : lose_step_r) * 37'(SHARE_RECIP);

  // hill climb terms
  assign gain_w  = 19'(share_r) * 19'(ACTION_COUNT - 1);
  assign pn_w    = (greedy_r == k_r[2:0]) ? $signed({2'b00, p_rd_r}) + $signed(gain_w)
                                          : $signed({2'b00, p_rd_r}) - $signed({3'b000, share_r});
  assign m_nxt_w = (pn_w < m_r) ? pn_w : m_r;

  // renormalization terms
  assign negm_w  = 18'(-m_r);
  assign den_w   = 20'(wphc_pkg::PROB_ONE) + 20'(ACTION_COUNT) * 20'(negm_w);
  assign numr_w  = ptmp_r[k_r[2:0]] - m_r;
  assign quo_clamp_w = (div_rsp.quotient > 34'(wphc_pkg::PROB_ONE)) ? wphc_pkg::PROB_ONE
                                                                    : div_rsp.quotient[16:0];

  // divider requests
  always_comb begin
    div_req = '0;
    case (state_r)
      wphc_pkg::ST_AWAIT: begin
        div_req.start    = 1'b1;
        div_req.dividend = 34'(dpa_mag_w[16:0]);
        div_req.divisor  = 20'(cnt_r);
      end
      wphc_pkg::ST_NSTART: begin
        div_req.start    = 1'b1;
        div_req.dividend = {numr_w[17:0], 16'h0000};
        div_req.divisor  = den_w;
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wphc_pkg::ST_CLEAR:  if (&clr_r) state_nxt = wphc_pkg::ST_IDLE;
      wphc_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = in_range_w ? wphc_pkg::ST_MAXN : wphc_pkg::ST_DONE;
      end
      wphc_pkg::ST_MAXN:   if (k_r == K_END) state_nxt = wphc_pkg::ST_QOLD;
      wphc_pkg::ST_QOLD:   state_nxt = wphc_pkg::ST_MULG;
      wphc_pkg::ST_MULG:   state_nxt = wphc_pkg::ST_MULA;
      wphc_pkg::ST_MULA:   state_nxt = wphc_pkg::ST_QWR;
      wphc_pkg::ST_QWR:    state_nxt = wphc_pkg::ST_ARD;
      wphc_pkg::ST_ARD:    state_nxt = wphc_pkg::ST_AWAIT;
      wphc_pkg::ST_AWAIT:  state_nxt = wphc_pkg::ST_ADIV;
      wphc_pkg::ST_ADIV:   if (div_rsp.done) state_nxt = wphc_pkg::ST_AWR;
      wphc_pkg::ST_AWR:    state_nxt = wphc_pkg::ST_AMUL;
      wphc_pkg::ST_AMUL:   state_nxt = wphc_pkg::ST_AACC;
      wphc_pkg::ST_AACC: begin
        state_nxt = (k_r == K_LAST) ? wphc_pkg::ST_SSTART : wphc_pkg::ST_ARD;
      end
      wphc_pkg::ST_SSTART: state_nxt = wphc_pkg::ST_SDIV;
      wphc_pkg::ST_SDIV:   state_nxt = wphc_pkg::ST_HRD;
      wphc_pkg::ST_HRD:    state_nxt = wphc_pkg::ST_HWR;
      wphc_pkg::ST_HWR: begin
        if (k_r != K_LAST) begin
          state_nxt = wphc_pkg::ST_HRD;
        end else begin
          state_nxt = (m_nxt_w < 0) ? wphc_pkg::ST_NSTART : wphc_pkg::ST_DONE;
        end
      end
      wphc_pkg::ST_NSTART: state_nxt = wphc_pkg::ST_NDIV;
      wphc_pkg::ST_NDIV:   if (div_rsp.done) state_nxt = wphc_pkg::ST_NWR;
      wphc_pkg::ST_NWR: begin
        state_nxt = (k_r == K_LAST) ? wphc_pkg::ST_DONE : wphc_pkg::ST_NSTART;
      end
      wphc_pkg::ST_DONE:   if (slot_free_w) state_nxt = wphc_pkg::ST_IDLE;
      default:             state_nxt = wphc_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wphc_pkg::ST_CLEAR;
      clr_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == wphc_pkg::ST_CLEAR) clr_r <= clr_r + 11'd1;
      case (state_r)
        wphc_pkg::ST_IDLE, wphc_pkg::ST_QWR, wphc_pkg::ST_SDIV: k_r <= '0;
        wphc_pkg::ST_MAXN: k_r <= (k_r == K_END) ? 4'd0 : k_r + 4'd1;
        wphc_pkg::ST_AACC: k_r <= (k_r == K_LAST) ? 4'd0 : k_r + 4'd1;
        wphc_pkg::ST_HWR:  k_r <= (k_r == K_LAST) ? 4'd0 : k_r + 4'd1;
        wphc_pkg::ST_NWR:  k_r <= k_r + 4'd1;
        default: ;
      endcase
      if (state_r == wphc_pkg::ST_DONE && slot_free_w) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    case (state_r)
      wphc_pkg::ST_IDLE: begin
        item_r   <= in_data;
        bad_r    <= !in_range_w;
        renorm_r <= 1'b0;
      end
      wphc_pkg::ST_MAXN: begin
        if (k_r != 4'd0 && (k_r == 4'd1 || q_rd_r > maxq_r)) maxq_r <= q_rd_r;
      end
      wphc_pkg::ST_MULG: begin
        qold_r <= q_rd_r;
        cnt_r  <= cnt_inc_w;
      end
      wphc_pkg::ST_QWR: begin
        resq_r <= nq_sat_w;
        diff_r <= '0;
      end
      wphc_pkg::ST_AWAIT: begin
        p_r    <= p_rd_r;
        avg_r  <= avg_rd_r;
        qk_r   <= q_rd_r;
        dneg_r <= dpa_w[17];
        if (k_r == 4'd0 || q_rd_r > gq_r) begin
          gq_r     <= q_rd_r;
          greedy_r <= k_r[2:0];
        end
      end
      wphc_pkg::ST_AWR:  avgn_r <= avg_new_w[16:0];
      wphc_pkg::ST_AACC: diff_r <= diff_r + 56'(prod_r);
      wphc_pkg::ST_SSTART: begin
        win_r <= diff_r > 0;
        m_r   <= '0;
      end
      wphc_pkg::ST_SDIV: share_r <= 16'(share_prod_w >> SHARE_SHIFT);
      wphc_pkg::ST_HWR: begin
        ptmp_r[k_r[2:0]] <= pn_w;
        m_r <= m_nxt_w;
      end
      wphc_pkg::ST_NWR: renorm_r <= 1'b1;
      wphc_pkg::ST_DONE: begin
        if (slot_free_w) begin
          if (bad_r) begin
            out_r <= '0;
          end else begin
            out_r.updated_q     <= resq_r;
            out_r.greedy_action <= greedy_r;
            out_r.winning       <= win_r;
            out_r.renormalized  <= renorm_r;
          end
        end
      end
      default: ;
    endcase
  end

  // memory addressing
  assign pa_addr = {item_r.agent, item_r.position, k_r[2:0]};
  assign v_addr  = {item_r.agent, item_r.position};
  always_comb begin
    case (state_r)
      wphc_pkg::ST_MAXN: q_raddr = {item_r.agent, item_r.next_position, k_r[2:0]};
      wphc_pkg::ST_QOLD: q_raddr = {item_r.agent, item_r.position, item_r.action};
      default:           q_raddr = pa_addr;
    endcase
  end

  // memory writes: clearing pass or update
  always_comb begin
    if (state_r == wphc_pkg::ST_CLEAR) begin
      q_we = 1'b1; p_we = 1'b1; a_we = 1'b1; v_we = 1'b1;
      q_waddr = clr_r; p_waddr = clr_r; a_waddr = clr_r;
      v_waddr = clr_r[10:3];
      q_wdata = wphc_pkg::Q_RESET;
      p_wdata = PROB_RESET;
      a_wdata = '0;
      v_wdata = '0;
    end else begin
      q_we = (state_r == wphc_pkg::ST_QWR);
      v_we = (state_r == wphc_pkg::ST_QWR);
      a_we = (state_r == wphc_pkg::ST_AWR);
      p_we = (state_r == wphc_pkg::ST_HWR) || (state_r == wphc_pkg::ST_NWR);
      q_waddr = {item_r.agent, item_r.position, item_r.action};
      p_waddr = pa_addr;
      a_waddr = pa_addr;
      v_waddr = v_addr;
      q_wdata = nq_sat_w;
      p_wdata = (state_r == wphc_pkg::ST_NWR) ? quo_clamp_w : wphc_pkg::clamp_prob(pn_w);
      a_wdata = avg_new_w[16:0];
      v_wdata = cnt_r;
    end
  end

  // Q store
  always_ff @(posedge clk) begin
    if (q_we) q_mem[q_waddr] <= q_wdata;
    q_rd_r <= q_mem[q_raddr];
  end

  // policy store
  always_ff @(posedge clk) begin
    if (p_we) p_mem[p_waddr] <= p_wdata;
    p_rd_r <= p_mem[pa_addr];
  end

  // average policy store
  always_ff @(posedge clk) begin
    if (a_we) avg_mem[a_waddr] <= a_wdata;
    avg_rd_r <= avg_mem[pa_addr];
  end

  // visit count store
  always_ff @(posedge clk) begin
    if (v_we) v_mem[v_waddr] <= v_wdata;
    v_rd_r <= v_mem[v_addr];
  end

`ifndef SYNTHESIS
  // divider is only started when idle
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken twice in a row");

  // no input during the clearing pass
  a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wphc_pkg::ST_CLEAR) |-> !in_ready)
    else $error("input ready while clearing");

  // renormalization only follows a negative minimum
  a_renorm: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wphc_pkg::ST_NSTART) |-> (m_r < 0))
    else $error("renormalization without negative entry");
`endif

endmodule

FILE: sim/wphc_checker.sv
// Checker for the WoLF-PHC learning update unit: predicts each result from
// accepted input beats and compares output beats. Depends on wphc_pkg.
module wphc_checker #(
  parameter int AGENT_COUNT  = 5,
  parameter int STATE_COUNT  = 32,
  parameter int ACTION_COUNT = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  wphc_pkg::in_beat_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  wphc_pkg::out_beat_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [3:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  input  logic                cfg_pready,
  output int                  fail_count,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE = 65536;

  // shadow registers and stores
  longint alpha, gamma, win_stp, lose_stp;
  logic signed [31:0] q_mem [AGENT_COUNT][STATE_COUNT][ACTION_COUNT];
  longint prob_mem [AGENT_COUNT][STATE_COUNT][ACTION_COUNT];
  longint avg_mem  [AGENT_COUNT][STATE_COUNT][ACTION_COUNT];
  int     visits   [AGENT_COUNT][STATE_COUNT];
  wphc_pkg::out_beat_t expected_q[$];

  function automatic longint floor16(longint v);
    return v >>> 16;
  endfunction

  // one learning step on the shadow stores
  function automatic wphc_pkg::out_beat_t learn_step(wphc_pkg::in_beat_t b);
    wphc_pkg::out_beat_t r;
    int ag, pos, act, nxt, greedy;
    longint maxq, target, nq, expc, expa, stp, share, m, den;
    r = '0;
    ag = b.agent; pos = b.position; act = b.action; nxt = b.next_position;
    if (ag >= AGENT_COUNT || pos >= STATE_COUNT || nxt >= STATE_COUNT ||
        act >= ACTION_COUNT) return r;
    // Q update
    maxq = q_mem[ag][nxt][0];
    for (int k = 1; k < ACTION_COUNT; k++)
      if (q_mem[ag][nxt][k] > maxq) maxq = q_mem[ag][nxt][k];
    target = longint'(b.reward) + floor16(gamma * maxq) - q_mem[ag][pos][act];
    nq = q_mem[ag][pos][act] + floor16(alpha * target);
    if (nq > 64'sd2147483647) nq = 64'sd2147483647;
    if (nq < -64'sd2147483648) nq = -64'sd2147483648;
    q_mem[ag][pos][act] = nq[31:0];
    // average policy
    if (visits[ag][pos] < 65535) visits[ag][pos]++;
    for (int k = 0; k < ACTION_COUNT; k++)
      avg_mem[ag][pos][k] += (prob_mem[ag][pos][k] - avg_mem[ag][pos][k]) /
                             longint'(visits[ag][pos]);
    // win or lose
    expc = 0; expa = 0;
    for (int k = 0; k < ACTION_COUNT; k++) begin
      expc += prob_mem[ag][pos][k] * q_mem[ag][pos][k];
      expa += avg_mem[ag][pos][k] * q_mem[ag][pos][k];
    end
    r.winning = expc > expa;
    stp = r.winning ? win_stp : lose_stp;
    // hill climb toward first max
    greedy = 0;
    for (int k = 1; k < ACTION_COUNT; k++)
      if (q_mem[ag][pos][k] > q_mem[ag][pos][greedy]) greedy = k;
    share = stp / (ACTION_COUNT - 1);
    m = 0;
    for (int k = 0; k < ACTION_COUNT; k++) begin
      if (k == greedy) prob_mem[ag][pos][k] += share * (ACTION_COUNT - 1);
      else prob_mem[ag][pos][k] -= share;
      if (prob_mem[ag][pos][k] < m) m = prob_mem[ag][pos][k];
    end
    if (m < 0) begin
      den = ONE + ACTION_COUNT * (-m);
      r.renormalized = 1'b1;
      for (int k = 0; k < ACTION_COUNT; k++)
        prob_mem[ag][pos][k] = ((prob_mem[ag][pos][k] - m) * ONE) / den;
    end
    for (int k = 0; k < ACTION_COUNT; k++) begin
      if (prob_mem[ag][pos][k] < 0) prob_mem[ag][pos][k] = 0;
      if (prob_mem[ag][pos][k] > ONE) prob_mem[ag][pos][k] = ONE;
    end
    r.updated_q = q_mem[ag][pos][act];
    r.greedy_action = greedy[2:0];
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    wphc_pkg::out_beat_t e;
    int errs;
    errs = 0;
    if (!rst_n) begin
      alpha <= 6554; gamma <= 58982; win_stp <= 655; lose_stp <= 2621;
      fail_count <= 0;
      expected_q.delete();
      for (int a = 0; a < AGENT_COUNT; a++)
        for (int s = 0; s < STATE_COUNT; s++) begin
          visits[a][s] = 0;
          for (int k = 0; k < ACTION_COUNT; k++) begin
            q_mem[a][s][k] = wphc_pkg::Q_RESET;
            prob_mem[a][s][k] = ONE / ACTION_COUNT;
            avg_mem[a][s][k] = 0;
          end
        end
    end else begin
      // register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          wphc_pkg::REG_LEARN_RATE: alpha    <= cfg_pwdata[15:0];
          wphc_pkg::REG_DISCOUNT:   gamma    <= cfg_pwdata[15:0];
          wphc_pkg::REG_WIN_STEP:   win_stp  <= cfg_pwdata[15:0];
          wphc_pkg::REG_LOSE_STEP:  lose_stp <= cfg_pwdata[15:0];
          default: ;
        endcase
      end
      // result beat against oldest expectation
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result beat with no expectation waiting");
          errs++;
        end else begin
          e = expected_q.pop_front();
          if (out_data.updated_q !== e.updated_q) begin
            $error("updated_q exp %0d got %0d", e.updated_q, out_data.updated_q);
            errs++;
          end
          if (out_data.greedy_action !== e.greedy_action) begin
            $error("greedy_action exp %0d got %0d", e.greedy_action,
                   out_data.greedy_action);
            errs++;
          end
          if (out_data.winning !== e.winning) begin
            $error("winning exp %0b got %0b", e.winning, out_data.winning);
            errs++;
          end
          if (out_data.renormalized !== e.renormalized) begin
            $error("renormalized exp %0b got %0b", e.renormalized,
                   out_data.renormalized);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      // input beat into the predictor
      if (in_valid && in_ready) expected_q.push_back(learn_step(in_data));
    end
  end
endmodule

FILE: sim/tb_wolf_phc_learning_update_unit.sv
// Testbench top for wolf_phc_learning_update_unit: drives input, output and
// register traffic and reports the verdict. Depends on wphc_pkg, wphc_checker.
module tb_wolf_phc_learning_update_unit;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_ready;
  wphc_pkg::in_beat_t in_data = '0;
  logic out_valid, out_ready = 1'b0;
  wphc_pkg::out_beat_t out_data;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [3:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0, cfg_prdata;
  logic cfg_pready;
  int fail_count, pending;
  bit hold_off = 1'b0;

  always #5 clk = ~clk;

  wolf_phc_learning_update_unit uut (.*);

  wphc_checker chk (.*);

  // register write: setup then access beat
  task automatic reg_write(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {16'($urandom_range(65535)), val};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  task automatic set_rates(logic [15:0] a, logic [15:0] g, logic [15:0] w,
                           logic [15:0] l);
    reg_write(wphc_pkg::REG_LEARN_RATE, a);
    reg_write(wphc_pkg::REG_DISCOUNT, g);
    reg_write(wphc_pkg::REG_WIN_STEP, w);
    reg_write(wphc_pkg::REG_LOSE_STEP, l);
  endtask

  // wait out in-flight work before touching registers
  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (600) @(negedge clk);
  endtask

  task automatic send_step(wphc_pkg::in_beat_t b);
    repeat ($urandom_range(6)) @(negedge clk);
    in_valid <= 1'b1; in_data <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // mostly in-range steps on a few hot states, with out-of-range noise
  function automatic wphc_pkg::in_beat_t random_step();
    wphc_pkg::in_beat_t b;
    b.agent = ($urandom_range(9) == 0) ? 3'($urandom_range(7))
                                       : 3'($urandom_range(4));
    b.position = 5'($urandom_range(3));
    if ($urandom_range(3) == 0) b.position = 5'($urandom_range(31));
    b.next_position = 5'($urandom_range(31));
    b.action = ($urandom_range(12) == 0) ? 3'($urandom_range(7))
                                         : 3'($urandom_range(4));
    case ($urandom_range(5))
      0: b.reward = $urandom;
      1: b.reward = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: b.reward = $signed(32'($urandom_range(1310720))) - 32'sd655360;
    endcase
    return b;
  endfunction

  // receiver: random stalls, one long hold-off
  initial begin
    int gap;
    while (1) begin
      @(negedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (3000) @(negedge clk);
        hold_off = 1'b0;
      end else if ($urandom_range(3) == 0) begin
        out_ready <= 1'b1;
      end else begin
        gap = $urandom_range(6);
        out_ready <= (gap == 0);
        repeat (gap) @(negedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    wphc_pkg::in_beat_t b;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    // directed: reset rates, extremes, agent and action out of range
    b = '{agent: 3'd0, position: 5'd0, action: 3'd0, next_position: 5'd0,
          reward: 32'sh7fffffff};
    send_step(b);
    b.reward = 32'sh80000000; b.action = 3'd4; send_step(b);
    b = '{3'd4, 5'd31, 3'd4, 5'd31, 32'sd0}; send_step(b);
    b = '{3'd7, 5'd1, 3'd1, 5'd1, 32'sd1}; send_step(b);
    b = '{3'd5, 5'd1, 3'd1, 5'd1, 32'sd1}; send_step(b);
    b = '{3'd1, 5'd1, 3'd7, 5'd1, 32'sd1}; send_step(b);
    b = '{3'd1, 5'd1, 3'd5, 5'd1, 32'sd1}; send_step(b);
    b = '{3'd2, 5'd2, 3'd2, 5'd2, -32'sd65536}; send_step(b);
    drain();
    // maximal rates: large steps force renormalization
    set_rates(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    reg_write(wphc_pkg::REG_LOSE_STEP, 16'hffff);
    for (int i = 0; i < 10; i++) begin
      b = '{3'd3, 5'd3, 3'(i % 5), 5'd3, $signed(32'(i * 40000)) - 32'sd100000};
      send_step(b);
    end
    drain();
    set_rates(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    for (int i = 0; i < 5; i++) send_step(random_step());
    // random phases, with the long hold-off in the first
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: set_rates(16'd6554, 16'd58982, 16'd655, 16'd2621);
        1: set_rates(16'hffff, 16'hffff, 16'd8000, 16'd30000);
        2: set_rates(16'd1, 16'd0, 16'hffff, 16'd0);
        3: set_rates(16'd30000, 16'd40000, 16'd0, 16'hffff);
        default: set_rates(16'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom));
      endcase
      if (ph == 0) hold_off = 1'b1;
      for (int i = 0; i < 220; i++) send_step(random_step());
    end
    drain();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(20ms);
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
